/* sv/arp_pkg.sv */
package arp_pkg;

  // Operation codes
  localparam logic [1:0] OP_RESOLVE = 2'd0;
  localparam logic [1:0] OP_LEARN   = 2'd1;
  localparam logic [1:0] OP_TICK    = 2'd2;

  // Status codes
  localparam logic [2:0] ST_HIT       = 3'd0;
  localparam logic [2:0] ST_MISS      = 3'd1;
  localparam logic [2:0] ST_PENDING   = 3'd2;
  localparam logic [2:0] ST_UPDATED   = 3'd3;
  localparam logic [2:0] ST_INSERTED  = 3'd4;
  localparam logic [2:0] ST_FULL      = 3'd5;
  localparam logic [2:0] ST_TICK_DONE = 3'd6;

  localparam int          TIMEOUT_W     = 16;
  localparam logic [15:0] TIMEOUT_RESET = 16'd3;
  localparam logic [4:0]  COUNT_MAX     = 5'd31;

  // Search token handed from cell to cell
  typedef struct packed {
    logic        active;
    logic        hit;
    logic        hit_complete;
    logic [47:0] hit_mac;
    logic        free;
    logic [4:0]  count;
  } probe_t;

  // Write broadcast to all cells at the end of a pass
  typedef struct packed {
    logic        fill;
    logic        update;
    logic        complete;
    logic [47:0] mac;
  } commit_t;

endpackage

/* sv/arp_cell.sv */
module arp_cell
  import arp_pkg::*;
#(
  parameter int STAMP_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic [1:0]            op,
  input  logic [31:0]           ip,
  input  logic [STAMP_BITS-1:0] now,
  input  logic [TIMEOUT_W-1:0]  timeout,
  input  probe_t                probe_in,
  output probe_t                probe_out,
  input  commit_t               commit
);

  localparam int CMP_W = (STAMP_BITS > TIMEOUT_W) ? STAMP_BITS : TIMEOUT_W;

  logic                  valid;
  logic                  complete;
  logic [31:0]           ip_reg;
  logic [47:0]           mac_reg;
  logic [STAMP_BITS-1:0] stamp;
  logic                  sel_hit;
  logic                  sel_free;

  logic                  match;
  logic [STAMP_BITS-1:0] age;
  logic                  expire;
  probe_t                probe_next;

  assign match  = valid && (ip_reg == ip);
  assign age    = now - stamp;
  assign expire = probe_in.active && (op == OP_TICK) && valid && !complete &&
                  (CMP_W'(age) >= CMP_W'(timeout));

  always_comb begin
    probe_next        = probe_in;
    probe_next.hit    = probe_in.hit | match;
    probe_next.free   = probe_in.free | !valid;
    if (match && !probe_in.hit) begin
      probe_next.hit_complete = complete;
      probe_next.hit_mac      = mac_reg;
    end
    if (expire && (probe_in.count != COUNT_MAX)) begin
      probe_next.count = probe_in.count + 5'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid     <= 1'b0;
      probe_out <= '0;
    end else begin
      probe_out <= probe_next;
      if (expire) begin
        valid <= 1'b0;
      end
      if (commit.fill && sel_free) begin
        valid <= 1'b1;
      end
    end
  end

  // Mark the first match and the first free slot as the token goes by
  always_ff @(posedge clk) begin
    if (probe_in.active) begin
      sel_hit  <= match && !probe_in.hit;
      sel_free <= !valid && !probe_in.free;
    end
    if (commit.fill && sel_free) begin
      complete <= commit.complete;
      ip_reg   <= ip;
      mac_reg  <= commit.mac;
      stamp    <= now;
    end
    if (commit.update && sel_hit) begin
      complete <= 1'b1;
      mac_reg  <= commit.mac;
    end
  end

endmodule

/* sv/arp_cache_table_top.sv */
// Channel   Signals                                   Transfer condition
// command   start, busy, operation, ip_addr, mac_addr start & !busy
// result    done, status, mac_result, released,       done (one cycle)
//           removed_count
// config    cfg_valid, cfg_ready, cfg_data            cfg_valid & cfg_ready
//
// A resolve, learn or tick item sends a search token along the row of ENTRIES
// entry cells one cell per cycle; then the write is broadcast and the result
// strobed. The next item is taken in the done cycle.
// Operation code 3 is taken and dropped without a result.
// rst is synchronous: it empties the table, zeroes time, sets timeout to 3.
// The receiver cannot stall; done lasts exactly one cycle.
module arp_cache_table_top
  import arp_pkg::*;
#(
  parameter int ENTRIES    = 16,
  parameter int STAMP_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  operation,
  input  logic [31:0] ip_addr,
  input  logic [47:0] mac_addr,
  output logic        done,
  output logic [2:0]  status,
  output logic [47:0] mac_result,
  output logic        released,
  output logic [4:0]  removed_count,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data
);

  logic [1:0]            op_q;
  logic [31:0]           ip_q;
  logic [47:0]           mac_q;
  logic [STAMP_BITS-1:0] now;
  logic [TIMEOUT_W-1:0]  timeout;
  probe_t                chain [ENTRIES+1];
  probe_t                tail;
  probe_t                head;
  commit_t               commit;
  logic                  accept;
  logic [2:0]            status_next;

  assign cfg_ready = 1'b1;
  assign accept    = start && !busy;
  assign tail      = chain[ENTRIES];

  for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
    arp_cell #(
      .STAMP_BITS(STAMP_BITS)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .op       (op_q),
      .ip       (ip_q),
      .now      (now),
      .timeout  (timeout),
      .probe_in (chain[i]),
      .probe_out(chain[i+1]),
      .commit   (commit)
    );
  end

  // Launch a fresh token for every used operation code
  always_comb begin
    head        = '0;
    head.active = accept && (operation inside {OP_RESOLVE, OP_LEARN, OP_TICK});
  end

  always_comb begin
    commit.fill     = tail.active && (op_q != OP_TICK) && !tail.hit && tail.free;
    commit.update   = tail.active && (op_q == OP_LEARN) && tail.hit;
    commit.complete = (op_q == OP_LEARN);
    commit.mac      = (op_q == OP_LEARN) ? mac_q : 48'd0;
  end

  always_comb begin
    case (op_q)
      OP_RESOLVE: begin
        if (tail.hit) begin
          status_next = tail.hit_complete ? ST_HIT : ST_PENDING;
        end else begin
          status_next = tail.free ? ST_MISS : ST_FULL;
        end
      end
      OP_LEARN: begin
        if (tail.hit) begin
          status_next = ST_UPDATED;
        end else begin
          status_next = tail.free ? ST_INSERTED : ST_FULL;
        end
      end
      default: status_next = ST_TICK_DONE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b0;
      done     <= 1'b0;
      now      <= '0;
      timeout  <= TIMEOUT_RESET;
      chain[0] <= '0;
    end else begin
      done     <= tail.active;
      chain[0] <= head;
      if (cfg_valid && cfg_ready) begin
        timeout <= cfg_data;
      end
      if (tail.active) begin
        busy <= 1'b0;
      end
      if (head.active) begin
        busy <= 1'b1;
        if (operation == OP_TICK) begin
          now <= now + 1'b1;
        end
      end
    end
  end

  // Hold the item for the length of the pass; register the result
  always_ff @(posedge clk) begin
    if (accept) begin
      op_q  <= operation;
      ip_q  <= ip_addr;
      mac_q <= mac_addr;
    end
    if (tail.active) begin
      status        <= status_next;
      mac_result    <= ((op_q == OP_RESOLVE) && tail.hit && tail.hit_complete) ?
                       tail.hit_mac : 48'd0;
      released      <= (op_q == OP_LEARN) && tail.hit && !tail.hit_complete;
      removed_count <= (op_q == OP_TICK) ? tail.count : 5'd0;
    end
  end

endmodule

/* verif/arp_cache_checker.sv */
`timescale 1ns / 100ps

module arp_cache_checker
  import arp_pkg::*;
#(
  parameter int ENTRIES = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic        busy,
  input  logic [1:0]  operation,
  input  logic [31:0] ip_addr,
  input  logic [47:0] mac_addr,
  input  logic        done,
  input  logic [2:0]  status,
  input  logic [47:0] mac_result,
  input  logic        released,
  input  logic [4:0]  removed_count,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [15:0] cfg_data,
  output int          error_count,
  output int          outstanding,
  output int          result_count
);

  typedef struct packed {
    logic [2:0]  status;
    logic [47:0] mac;
    logic        released;
    logic [4:0]  removed;
  } arp_reply_t;

  // Shadow copy of the cache contents
  logic        slot_valid [ENTRIES];
  logic        slot_done  [ENTRIES];
  logic [31:0] slot_ip    [ENTRIES];
  logic [47:0] slot_mac   [ENTRIES];
  logic [15:0] slot_stamp [ENTRIES];
  logic [15:0] tick_now;
  logic [15:0] age_limit;

  arp_reply_t replies_due [$];

  initial begin
    error_count  = 0;
    outstanding  = 0;
    result_count = 0;
  end

  task report_mismatch(input string what, input logic [47:0] got, input logic [47:0] want);
    $display("MISMATCH %s: got 0x%0h, expected 0x%0h at %0t", what, got, want, $time);
    error_count++;
  endtask

  task predict_reply(input logic [1:0] op, input logic [31:0] ip, input logic [47:0] mac,
                     output logic answers, output arp_reply_t reply);
    int          hit_idx;
    int          free_idx;
    logic [15:0] age;
    reply    = '0;
    answers  = 1'b1;
    hit_idx  = -1;
    free_idx = -1;
    for (int i = 0; i < ENTRIES; i++) begin
      if (slot_valid[i] && slot_ip[i] == ip && hit_idx < 0) hit_idx = i;
      if (!slot_valid[i] && free_idx < 0) free_idx = i;
    end
    case (op)
      OP_RESOLVE: begin
        if (hit_idx >= 0) begin
          if (slot_done[hit_idx]) begin
            reply.status = ST_HIT;
            reply.mac    = slot_mac[hit_idx];
          end else begin
            reply.status = ST_PENDING;
          end
        end else if (free_idx < 0) begin
          reply.status = ST_FULL;
        end else begin
          slot_valid[free_idx] = 1'b1;
          slot_done[free_idx]  = 1'b0;
          slot_ip[free_idx]    = ip;
          slot_mac[free_idx]   = '0;
          slot_stamp[free_idx] = tick_now;
          reply.status = ST_MISS;
        end
      end
      OP_LEARN: begin
        if (hit_idx >= 0) begin
          slot_mac[hit_idx] = mac;
          if (!slot_done[hit_idx]) begin
            slot_done[hit_idx] = 1'b1;
            reply.released = 1'b1;
          end
          reply.status = ST_UPDATED;
        end else if (free_idx < 0) begin
          reply.status = ST_FULL;
        end else begin
          slot_valid[free_idx] = 1'b1;
          slot_done[free_idx]  = 1'b1;
          slot_ip[free_idx]    = ip;
          slot_mac[free_idx]   = mac;
          slot_stamp[free_idx] = tick_now;
          reply.status = ST_INSERTED;
        end
      end
      OP_TICK: begin
        tick_now = tick_now + 16'd1;
        // age is taken after time has advanced
        for (int i = 0; i < ENTRIES; i++) begin
          if (slot_valid[i] && !slot_done[i]) begin
            age = tick_now - slot_stamp[i];
            if (age >= age_limit) begin
              slot_valid[i] = 1'b0;
              if (reply.removed < COUNT_MAX) reply.removed = reply.removed + 5'd1;
            end
          end
        end
        reply.status = ST_TICK_DONE;
      end
      default: answers = 1'b0;
    endcase
  endtask

  always @(posedge clk) begin : watch
    arp_reply_t due;
    logic       answers;
    if (rst) begin
      for (int i = 0; i < ENTRIES; i++) slot_valid[i] = 1'b0;
      tick_now  = '0;
      age_limit = TIMEOUT_RESET;
      replies_due.delete();
    end else begin
      if (done) begin
        result_count++;
        if (replies_due.size() == 0) begin
          report_mismatch("result with nothing pending, status", {45'd0, status}, '0);
        end else begin
          due = replies_due.pop_front();
          if (status !== due.status)
            report_mismatch("status", {45'd0, status}, {45'd0, due.status});
          if (mac_result !== due.mac)
            report_mismatch("mac_result", mac_result, due.mac);
          if (released !== due.released)
            report_mismatch("released", {47'd0, released}, {47'd0, due.released});
          if (removed_count !== due.removed)
            report_mismatch("removed_count", {43'd0, removed_count}, {43'd0, due.removed});
        end
      end
      if (cfg_valid && cfg_ready) age_limit = cfg_data;
      if (start && !busy) begin
        predict_reply(operation, ip_addr, mac_addr, answers, due);
        if (answers) replies_due.push_back(due);
      end
    end
    outstanding <= replies_due.size();
  end

endmodule

/* verif/tb_arp_cache_table_top.sv */
`timescale 1ns / 100ps

module tb_arp_cache_table_top;
  import arp_pkg::*;

  localparam int         ENTRIES      = 16;
  localparam int         DRAIN_CYCLES = ENTRIES + 6;
  localparam int         PHASES       = 10;
  localparam int         PHASE_ITEMS  = 185;
  localparam int         POOL_SIZE    = 11;
  localparam int         SCRATCH_SIZE = 6;
  localparam logic [1:0] OP_UNUSED    = 2'd3;

  logic        clk       = 1'b0;
  logic        rst       = 1'b1;
  logic        start     = 1'b0;
  logic [1:0]  operation = OP_RESOLVE;
  logic [31:0] ip_addr   = '0;
  logic [47:0] mac_addr  = '0;
  logic        cfg_valid = 1'b0;
  logic [15:0] cfg_data  = '0;
  logic        busy;
  logic        done;
  logic [2:0]  status;
  logic [47:0] mac_result;
  logic        released;
  logic [4:0]  removed_count;
  logic        cfg_ready;

  int error_count;
  int outstanding;
  int result_count;
  int issued_count   = 0;
  int settings_count = 0;
  int burst_left     = 0;
  bit idle_on        = 1'b0;

  logic [31:0] ip_pool      [POOL_SIZE];
  logic [31:0] scratch_ips  [SCRATCH_SIZE];
  logic [15:0] phase_limits [PHASES];

  arp_cache_table_top #(.ENTRIES(ENTRIES), .STAMP_BITS(16)) i_dut (
    .clk(clk), .rst(rst),
    .start(start), .busy(busy),
    .operation(operation), .ip_addr(ip_addr), .mac_addr(mac_addr),
    .done(done), .status(status), .mac_result(mac_result),
    .released(released), .removed_count(removed_count),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  arp_cache_checker #(.ENTRIES(ENTRIES)) i_checker (
    .clk(clk), .rst(rst),
    .start(start), .busy(busy),
    .operation(operation), .ip_addr(ip_addr), .mac_addr(mac_addr),
    .done(done), .status(status), .mac_result(mac_result),
    .released(released), .removed_count(removed_count),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .error_count(error_count), .outstanding(outstanding), .result_count(result_count)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  initial begin
    #3000000;
    $display("DONE: errors detected");
    $finish;
  end

  // Hold start low for a random gap, then present the command until transfer
  task send_command(input logic [1:0] op, input logic [31:0] ip, input logic [47:0] mac);
    int gap;
    if (burst_left == 0) begin
      idle_on    = ($urandom_range(0, 3) != 0);
      burst_left = $urandom_range(10, 60);
    end
    burst_left--;
    gap = idle_on ? $urandom_range(0, 16) : 0;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start     <= 1'b1;
    operation <= op;
    ip_addr   <= ip;
    mac_addr  <= mac;
    do @(posedge clk); while (busy);
    issued_count++;
  endtask

  // Drain all results, then allow for a dropped command still in flight
  task wait_idle();
    start <= 1'b0;
    @(negedge clk);
    while (outstanding != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task write_timeout(input logic [15:0] value);
    wait_idle();
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    settings_count++;
  endtask

  function automatic logic [47:0] random_mac();
    logic [63:0] raw;
    raw = {$urandom(), $urandom()};
    return raw[47:0];
  endfunction

  initial begin : stimulus
    int          pick;
    int          active;
    logic [1:0]  op;
    logic [31:0] ip;

    for (int i = 0; i < POOL_SIZE; i++) ip_pool[i] = $urandom();
    phase_limits = '{TIMEOUT_RESET, 16'd0, 16'd1, 16'hFFFF, 16'd2, 16'd4,
                     16'd0, 16'd1, 16'hFFFE, 16'd0};
    phase_limits[6] = 16'($urandom_range(1, 20));
    phase_limits[9] = 16'($urandom_range(0, 65535));

    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: lookup life cycle, extremes of address and MAC, expiry
    send_command(OP_RESOLVE, 32'h0000_0000, 48'h0);
    send_command(OP_RESOLVE, 32'h0000_0000, 48'hFFFF_FFFF_FFFF);
    send_command(OP_LEARN,   32'h0000_0000, 48'hFFFF_FFFF_FFFF);
    send_command(OP_RESOLVE, 32'h0000_0000, 48'h0);
    send_command(OP_LEARN,   32'h0000_0000, 48'h0);
    send_command(OP_RESOLVE, 32'h0000_0000, 48'h0);
    send_command(OP_LEARN,   32'hFFFF_FFFF, 48'hAAAA_AAAA_AAAA);
    send_command(OP_RESOLVE, 32'hFFFF_FFFF, 48'h0);
    send_command(OP_UNUSED,  32'h5555_5555, 48'h5555_5555_5555);
    send_command(OP_RESOLVE, 32'h0000_0001, 48'h0);
    send_command(OP_RESOLVE, 32'h8000_0000, 48'h0);
    send_command(OP_TICK,    32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF);
    send_command(OP_TICK,    32'h0,         48'h0);
    send_command(OP_TICK,    32'h0,         48'h0);
    send_command(OP_LEARN,   32'h0000_0002, 48'h5555_5555_5555);
    send_command(OP_RESOLVE, 32'h7FFF_FFFF, 48'h0);
    // zero timeout drops every pending entry on the next tick
    write_timeout(16'd0);
    send_command(OP_TICK,    32'h0,         48'h0);
    write_timeout(TIMEOUT_RESET);

    for (int ph = 0; ph < PHASES; ph++) begin
      if (ph > 0) write_timeout(phase_limits[ph]);
      for (int i = 0; i < SCRATCH_SIZE; i++) scratch_ips[i] = $urandom();
      // bring one more stable address into play each phase
      active = (ph + 2 < POOL_SIZE) ? ph + 2 : POOL_SIZE;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        pick = $urandom_range(0, 99);
        if (pick < 5)       op = OP_UNUSED;
        else if (pick < 30) op = OP_TICK;
        else if (pick < 60) op = OP_LEARN;
        else                op = OP_RESOLVE;
        pick = $urandom_range(0, 99);
        if (op == OP_LEARN) begin
          if (ph == PHASES - 1 && pick < 30)  ip = $urandom();
          else if (pick < 8)                  ip = scratch_ips[$urandom_range(0, SCRATCH_SIZE - 1)];
          else                                ip = ip_pool[$urandom_range(0, active - 1)];
        end else begin
          if (pick < 50)      ip = ip_pool[$urandom_range(0, active - 1)];
          else if (pick < 90) ip = scratch_ips[$urandom_range(0, SCRATCH_SIZE - 1)];
          else                ip = $urandom();
        end
        send_command(op, ip, random_mac());
      end
    end

    wait_idle();
    $display("Covered %0d commands with %0d results checked", issued_count, result_count);
    $display("Timeout register rewritten %0d times, including 0 and 65535", settings_count);
    if (error_count == 0 && outstanding == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
